// ----- rtl/grb_pkg.sv -----
// Shared constants, register codes and types of the Gaussian row blur.
// Used by the interfaces, the register block, the multiply-accumulate unit
// and the top level. Depends on nothing.
package grb_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_HALF_WIDTH_DEF = 6;
	localparam int SAMPLE_BITS_DEF    = 16;

	// Fixed widths of the register file and the result
	localparam int NUM_COEFS     = 7;
	localparam int COEF_BITS     = 16;
	localparam int COEF_IDX_BITS = 3;
	localparam int HW_REG_BITS   = 3;
	localparam int OUT_BITS      = 16;
	localparam int FRAC_BITS     = 14;
	localparam int ADDR_BITS     = 5;
	localparam int DATA_BITS     = 32;

	// Register indexes (byte address is four times the index)
	typedef enum logic [2:0] {
		REG_HALF_WIDTH  = 3'd0,
		REG_COEF_CENTER = 3'd1,
		REG_COEF_DIST1  = 3'd2,
		REG_COEF_DIST2  = 3'd3,
		REG_COEF_DIST3  = 3'd4,
		REG_COEF_DIST4  = 3'd5,
		REG_COEF_DIST5  = 3'd6,
		REG_COEF_DIST6  = 3'd7
	} reg_idx_t;

	// Coefficient bank, entry 0 is the centre tap
	typedef logic [NUM_COEFS-1:0][COEF_BITS-1:0] coef_arr_t;

	// Control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic start;
		logic issue;
	} grb_mac_ctl_t;

endpackage

// ----- rtl/grb_ifs.sv -----
// Valid/ready stream interfaces of the Gaussian row blur: the sample
// stream going in and the blurred stream coming out.
// Depends on grb_pkg for the default sample width and the result width.
interface grb_sample_if #(
	parameter int SAMPLE_BITS = grb_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          row_end;

	modport source (output valid, output sample, output row_end, input ready);
	modport sink (input valid, input sample, input row_end, output ready);
endinterface

interface grb_blur_if;
	logic                                valid;
	logic                                ready;
	logic signed [grb_pkg::OUT_BITS-1:0] blurred;
	logic                                row_done;

	modport source (output valid, output blurred, output row_done, input ready);
	modport sink (input valid, input blurred, input row_done, output ready);
endinterface

// ----- rtl/grb_apb_regs.sv -----
// APB register block: kernel half width and the seven unsigned Q2.14 tap weights.
// Depends on grb_pkg for register codes and the coefficient bank type.
module grb_apb_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [grb_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [grb_pkg::DATA_BITS-1:0]       pwdata,
	output logic [grb_pkg::DATA_BITS-1:0]       prdata,
	output logic                                pready,
	output logic [grb_pkg::HW_REG_BITS-1:0]     half_width,
	output grb_pkg::coef_arr_t                  coefs
);
	import grb_pkg::*;

	reg_idx_t                   reg_idx;
	logic                       wr_en;
	logic [HW_REG_BITS-1:0]     half_width_q;
	coef_arr_t                  coefs_q;
	logic [COEF_IDX_BITS-1:0]   coef_sel;

	// Address decode; the access phase completes at once
	assign reg_idx  = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign coef_sel = COEF_IDX_BITS'(reg_idx - REG_COEF_CENTER);
	assign wr_en    = psel && penable && pwrite;
	assign pready   = 1'b1;

	// Register writes; the centre tap resets to unity, the others to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= '0;
			coefs_q      <= {{((NUM_COEFS - 1) * COEF_BITS){1'b0}},
			                 COEF_BITS'(1 << FRAC_BITS)};
		end else if (wr_en) begin
			case (reg_idx)
				REG_HALF_WIDTH: half_width_q <= pwdata[HW_REG_BITS-1:0];
				default:        coefs_q[coef_sel] <= pwdata[COEF_BITS-1:0];
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_HALF_WIDTH: prdata = DATA_BITS'(half_width_q);
			default:        prdata = DATA_BITS'(coefs_q[coef_sel]);
		endcase
	end

	assign half_width = half_width_q;
	assign coefs      = coefs_q;

endmodule

// ----- rtl/grb_mac.sv -----
// Shared multiply-accumulate unit with rounding and saturation to 16 bits.
// One tap product per cycle, registered before the accumulator.
// Depends on grb_pkg for the control struct and fixed-point constants.
module grb_mac #(
	parameter int SAMPLE_BITS = grb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  grb_pkg::grb_mac_ctl_t               ctl,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic [grb_pkg::COEF_BITS-1:0]       coef,
	output logic signed [grb_pkg::OUT_BITS-1:0] result
);
	import grb_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 1;
	localparam int ACC_BITS  = SAMPLE_BITS + 24;
	localparam int Q_BITS    = ACC_BITS - FRAC_BITS;
	localparam logic signed [Q_BITS-1:0] SAT_MAX = Q_BITS'(32767);
	localparam logic signed [Q_BITS-1:0] SAT_MIN = -Q_BITS'(32768);

	logic signed [PROD_BITS-1:0] prod;
	logic signed [PROD_BITS-1:0] prod_s1;
	logic                        vld_s1;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [ACC_BITS-1:0]  rounded;
	logic signed [Q_BITS-1:0]    quot;

	// Signed sample times unsigned weight
	assign prod = PROD_BITS'(sample) * $signed({1'b0, coef});

	// Product stage and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			prod_s1 <= '0;
			acc_q   <= '0;
		end else if (ctl.start) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1  <= ctl.issue;
			prod_s1 <= prod;
			if (vld_s1) begin
				acc_q <= acc_q + ACC_BITS'(prod_s1);
			end
		end
	end

	// Round half up, floor by the fraction width, then clamp
	always_comb begin
		rounded = acc_q + ACC_BITS'(1 << (FRAC_BITS - 1));
		quot    = rounded[ACC_BITS-1:FRAC_BITS];
		if (quot > SAT_MAX) begin
			result = OUT_BITS'(32767);
		end else if (quot < SAT_MIN) begin
			result = OUT_BITS'(-32768);
		end else begin
			result = quot[OUT_BITS-1:0];
		end
	end

endmodule

// ----- rtl/gaussian_row_blur_top.sv -----
// Top level of the Gaussian row blur: history line, tap sequencer and output
// register around one shared multiply-accumulate unit.
// Depends on grb_pkg, grb_ifs, grb_apb_regs and grb_mac.
//
// Channel    Role    Handshake          Payload
// samples    sink    valid/ready        sample, row_end
// filtered   source  valid/ready        blurred, row_done
// APB        slave   psel/penable       half_width, coef_center, coef_dist1..6
//
// Each output passes its taps one by one through the shared multiplier, then
// a drain step empties the product stage and a rounding step loads the output
// register; taps past the end of a row are skipped. A sample that yields no
// output leaves the sequencer idle for the next sample. A row end yields up to
// h+1 outputs back to back. Reset is asynchronous and clears the history, the
// counters and the weights to the unit kernel. A stall on the output holds the
// sequencer in its rounding step; samples are taken only while the sequencer
// is idle.
module gaussian_row_blur_top #(
	parameter int MAX_HALF_WIDTH = grb_pkg::MAX_HALF_WIDTH_DEF,
	parameter int SAMPLE_BITS    = grb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [grb_pkg::ADDR_BITS-1:0] paddr,
	input  logic [grb_pkg::DATA_BITS-1:0] pwdata,
	output logic [grb_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	grb_sample_if.sink                    samples,
	grb_blur_if.source                    filtered
);
	import grb_pkg::*;

	localparam int TAPS     = 2 * MAX_HALF_WIDTH + 1;
	localparam int TAP_BITS = $clog2(TAPS);
	localparam int HW_BITS  = $clog2(MAX_HALF_WIDTH + 1);
	localparam logic [HW_REG_BITS-1:0] MAX_HW = HW_REG_BITS'(MAX_HALF_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND
	} state_t;

	state_t                        state_q;
	logic [HW_REG_BITS-1:0]        half_width;
	coef_arr_t                     coefs;
	logic signed [SAMPLE_BITS-1:0] hist_q [TAPS];
	logic [HW_BITS-1:0]            primed_q;
	logic [HW_BITS-1:0]            h_q;
	logic [HW_BITS-1:0]            c_q;
	logic [TAP_BITS-1:0]           idx_q;
	logic                          last_q;
	logic                          out_valid_q;
	logic signed [OUT_BITS-1:0]    blurred_q;
	logic                          row_done_q;

	logic [HW_BITS-1:0]            h_eff;
	logic                          p_ge_h;
	logic                          in_xfer;
	logic                          emit;
	logic [HW_BITS-1:0]            c_start;
	logic [HW_BITS-1:0]            c_next;
	logic [TAP_BITS-1:0]           c_ext;
	logic [TAP_BITS-1:0]           lo;
	logic [TAP_BITS-1:0]           tap_off;
	logic                          out_free;
	logic                          out_load;
	logic                          more;
	logic                          row_clear;
	grb_mac_ctl_t                  mac_ctl;
	logic [COEF_BITS-1:0]          coef_sel;
	logic signed [OUT_BITS-1:0]    mac_result;

	grb_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.half_width (half_width),
		.coefs      (coefs)
	);

	// Sequencer decisions
	always_comb begin
		h_eff     = (half_width > MAX_HW) ? HW_BITS'(MAX_HW) : HW_BITS'(half_width);
		p_ge_h    = primed_q >= h_eff;
		in_xfer   = samples.valid && samples.ready;
		emit      = samples.row_end || p_ge_h;
		c_start   = p_ge_h ? h_eff : primed_q;
		c_next    = c_q - HW_BITS'(1);
		c_ext     = TAP_BITS'(c_q);
		lo        = (c_q >= h_q) ? TAP_BITS'(c_q - h_q) : '0;
		tap_off   = (c_ext >= idx_q) ? c_ext - idx_q : idx_q - c_ext;
		coef_sel  = coefs[COEF_IDX_BITS'(tap_off)];
		out_free  = !out_valid_q || filtered.ready;
		out_load  = (state_q == ST_ROUND) && out_free;
		more      = last_q && (c_q != '0);
		row_clear = out_load && last_q && !more;
		mac_ctl.start = ((state_q == ST_IDLE) && in_xfer && emit)
		             || (out_load && more);
		mac_ctl.issue = state_q == ST_MAC;
	end

	assign samples.ready     = state_q == ST_IDLE;
	assign filtered.valid    = out_valid_q;
	assign filtered.blurred  = blurred_q;
	assign filtered.row_done = row_done_q;

	grb_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.sample (hist_q[idx_q]),
		.coef   (coef_sel),
		.result (mac_result)
	);

	// History line, newest sample at the front; cleared after a row ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (row_clear) begin
			for (int i = 0; i < TAPS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (in_xfer) begin
			hist_q[0] <= samples.sample;
			for (int i = 1; i < TAPS; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	// State machine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= '0;
			h_q         <= '0;
			c_q         <= '0;
			idx_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			blurred_q   <= '0;
			row_done_q  <= 1'b0;
		end else begin
			// The output register fills from the rounding step and empties on a transfer
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (filtered.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						h_q    <= h_eff;
						c_q    <= c_start;
						idx_q  <= TAP_BITS'(c_start) + TAP_BITS'(h_eff);
						last_q <= samples.row_end;
						if (samples.row_end) begin
							primed_q <= '0;
						end else if (!p_ge_h) begin
							primed_q <= primed_q + HW_BITS'(1);
						end
						if (emit) begin
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					if (idx_q == lo) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q - TAP_BITS'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (out_free) begin
						blurred_q   <= mac_result;
						row_done_q  <= last_q && !more;
						if (more) begin
							c_q     <= c_next;
							idx_q   <= TAP_BITS'(c_next) + TAP_BITS'(h_q);
							state_q <= ST_MAC;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The fill count never passes the largest half width
	a_primed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q <= HW_BITS'(MAX_HALF_WIDTH))
		else $error("primed count above the largest half width");

	// A tap index never reaches past the kernel around its centre
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (idx_q <= c_ext + TAP_BITS'(h_q)) && (idx_q >= lo))
		else $error("tap index outside the kernel window");

	// The last output of a row leaves the history empty for the next row
	a_row_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		row_clear |=> (state_q == ST_IDLE) && (primed_q == '0) && (hist_q[0] == '0))
		else $error("history not cleared after the end of a row");

	// A sample that is due an output starts the tap sequence at once
	a_emit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && emit) |=> (state_q == ST_MAC))
		else $error("due output did not start the tap sequence");

endmodule
